@@ src/fqkr_pkg.sv @@
// Shared types, command codes and status codes for the keyed-removal queue.
package fqkr_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int FIELD_BITS   = 32;
    localparam int COUNT_BITS   = 7;

    localparam logic [2:0] CMD_ENQ    = 3'd0;
    localparam logic [2:0] CMD_DEQ    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_CHECK  = 3'd3;
    localparam logic [2:0] CMD_FIND   = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [FIELD_BITS-1:0] member_key;
        logic [FIELD_BITS-1:0] book_key;
        logic [FIELD_BITS-1:0] stamp;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic                  found;
        logic [FIELD_BITS-1:0] hit_member;
        logic [FIELD_BITS-1:0] hit_book;
        logic [FIELD_BITS-1:0] hit_stamp;
        logic [COUNT_BITS-1:0] entries;
        logic                  is_empty;
    } t_out_item;

endpackage

@@ src/fqkr_core.sv @@
// Command sequencer with the entry memory, circular head pointer and search walk.
module fqkr_core #(
    parameter int DEPTH    = fqkr_pkg::DEPTH_DEF,
    parameter int KEY_BITS = fqkr_pkg::KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  fqkr_pkg::t_in_item  i_req,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output fqkr_pkg::t_out_item o_res
);

    localparam int FB = fqkr_pkg::FIELD_BITS;
    localparam int KW = (KEY_BITS < FB) ? KEY_BITS : FB;
    localparam int EW = 2 * KW + FB;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd_data;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_fill, n_fill;
    logic [CW-1:0]      r_ridx, n_ridx;
    logic               r_cmp_v, n_cmp_v;
    logic [AW-1:0]      r_cmp_idx, n_cmp_idx;
    logic               r_hit_valid, n_hit_valid;
    logic [AW-1:0]      r_hit_idx, n_hit_idx;
    logic [1:0]         r_status, n_status;
    logic               r_found, n_found;
    fqkr_pkg::t_in_item r_req, n_req;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] rd_member;
    logic [KW-1:0] rd_book;
    logic [FB-1:0] rd_stamp;
    logic          scan_hit;
    logic [FB-1:0] out_member;
    logic [FB-1:0] out_book;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_member = r_rd_data[EW-1 -: KW];
    assign rd_book   = r_rd_data[FB+KW-1 -: KW];
    assign rd_stamp  = r_rd_data[FB-1:0];

    assign scan_hit = r_cmp_v && (rd_book == r_req.book_key[KW-1:0])
                      && ((r_req.cmd == fqkr_pkg::CMD_FIND)
                          || (rd_member == r_req.member_key[KW-1:0]));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_ridx      = r_ridx;
        n_cmp_v     = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_hit_valid = r_hit_valid;
        n_hit_idx   = r_hit_idx;
        n_status    = r_status;
        n_found     = r_found;
        n_req       = r_req;
        wr_en       = 1'b0;
        wr_addr     = phys(r_head, r_fill);
        wr_data     = {i_req.member_key[KW-1:0], i_req.book_key[KW-1:0], i_req.stamp};
        rd_addr     = phys(r_head, r_ridx);
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req       = i_req;
                    n_status    = fqkr_pkg::ST_DONE;
                    n_found     = 1'b0;
                    n_hit_valid = 1'b0;
                    n_hit_idx   = '0;
                    n_ridx      = '0;
                    n_state     = S_FETCH;
                    unique case (i_req.cmd)
                        fqkr_pkg::CMD_ENQ: begin
                            if (r_fill == CW'(DEPTH)) begin
                                n_status = fqkr_pkg::ST_FULL;
                            end else begin
                                wr_en  = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        fqkr_pkg::CMD_DEQ: begin
                            if (r_fill == '0) begin
                                n_status = fqkr_pkg::ST_NOMATCH;
                            end else begin
                                n_head = phys(r_head, CW'(1));
                                n_fill = r_fill - 1'b1;
                            end
                        end
                        fqkr_pkg::CMD_REMOVE, fqkr_pkg::CMD_CHECK,
                        fqkr_pkg::CMD_FIND: begin
                            if (r_fill == '0) begin
                                n_status = fqkr_pkg::ST_NOMATCH;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_ridx    = r_ridx + 1'b1;
                n_cmp_v   = (r_ridx < r_fill);
                n_cmp_idx = r_ridx[AW-1:0];
                if (scan_hit) begin
                    n_found = 1'b1;
                    n_cmp_v = 1'b0;
                    if (r_req.cmd == fqkr_pkg::CMD_REMOVE) begin
                        n_ridx  = CW'(r_cmp_idx) + 1'b1;
                        n_state = S_SHIFT;
                    end else begin
                        n_hit_valid = (r_req.cmd == fqkr_pkg::CMD_FIND);
                        n_hit_idx   = r_cmp_idx;
                        n_state     = S_FETCH;
                    end
                end else if (r_cmp_v && (CW'(r_cmp_idx) == r_fill - 1'b1)) begin
                    n_status = fqkr_pkg::ST_NOMATCH;
                    n_cmp_v  = 1'b0;
                    n_state  = S_FETCH;
                end
            end
            S_SHIFT: begin
                wr_en   = r_cmp_v;
                wr_addr = phys(r_head, CW'(r_cmp_idx));
                wr_data = r_rd_data;
                if (r_ridx < r_fill) begin
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_ridx[AW-1:0] - 1'b1;
                    n_ridx    = r_ridx + 1'b1;
                end else begin
                    n_fill  = r_fill - 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                rd_addr = phys(r_head, r_hit_valid ? CW'(r_hit_idx) : '0);
                n_state = S_DONE;
            end
            S_DONE: begin
                rd_addr = phys(r_head, r_hit_valid ? CW'(r_hit_idx) : '0);
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_cmp_v <= n_cmp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx      <= n_ridx;
        r_cmp_idx   <= n_cmp_idx;
        r_hit_valid <= n_hit_valid;
        r_hit_idx   <= n_hit_idx;
        r_status    <= n_status;
        r_found     <= n_found;
        r_req       <= n_req;
    end

    always_comb begin
        out_member         = '0;
        out_book           = '0;
        out_member[KW-1:0] = rd_member;
        out_book[KW-1:0]   = rd_book;
        o_res.status       = r_status;
        o_res.found        = r_found;
        o_res.entries      = fqkr_pkg::COUNT_BITS'(r_fill);
        o_res.is_empty     = (r_fill == '0);
        if (r_hit_valid || (r_fill != '0)) begin
            o_res.hit_member = out_member;
            o_res.hit_book   = out_book;
            o_res.hit_stamp  = rd_stamp;
        end else begin
            o_res.hit_member = '0;
            o_res.hit_book   = '0;
            o_res.hit_stamp  = '0;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill level exceeds depth");

    a_head_moves_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_head))
        else $error("head pointer moved outside command acceptance");

    a_scan_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_fill))
        else $error("fill level changed during search");

    a_enqueue_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_valid && i_req.cmd == fqkr_pkg::CMD_ENQ
         && r_fill != CW'(DEPTH)) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("enqueue did not add one entry");

    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_FETCH || r_state == S_DONE) |-> !wr_en)
        else $error("memory written outside enqueue or compaction");

endmodule

@@ src/fifo_queue_with_keyed_removal.sv @@
// Top level of the ordered queue with keyed removal and its output register.
// Enqueue, dequeue and unknown commands go through the fetch and done states.
// Remove, check and find walk the stored entries through one memory read port,
// one entry per cycle, and a removal then compacts the entries behind the hit.
// A new transaction is accepted once the result has left the sequencer.
// Reset empties the queue at once; entry storage is not cleared.
module fifo_queue_with_keyed_removal #(
    parameter int DEPTH    = fqkr_pkg::DEPTH_DEF,
    parameter int KEY_BITS = fqkr_pkg::KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fqkr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fqkr_pkg::t_out_item o_out_item
);

    logic                req_ready;
    logic                res_valid;
    logic                res_ready;
    fqkr_pkg::t_out_item res;

    logic                r_out_valid, n_out_valid;
    fqkr_pkg::t_out_item r_out_item, n_out_item;

    fqkr_core #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (req_ready),
        .i_req       (i_in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out_item  = res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = !req_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
